// ===== hdl/lorawan_mic_cmac_defines.svh =====
// Assertion macros used by the checker file
`ifndef LORAWAN_MIC_CMAC_DEFINES_SVH
`define LORAWAN_MIC_CMAC_DEFINES_SVH

// Clocked implication, disabled while reset is low
`define LMIC_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lmic check failed");

// Clocked implication that stays armed through reset
`define LMIC_ASSERT_RST(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("lmic reset check failed");

`endif

// ===== hdl/lmic_pkg.sv =====
// Shared types, constants and AES functions for the LoRaWAN MIC block
package lmic_pkg;

	localparam int FIFO_DEPTH_DEF = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NWK_KEY_HI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NWK_KEY_LO = 2'd2;

	localparam logic [7:0] B0_TAG   = 8'h49;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [7:0] RED_POLY = 8'h87;
	localparam logic [3:0] LAST_POS = 4'd15;
	localparam logic [3:0] LAST_RND = 4'd10;

	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  len;
		logic [15:0] ctr;
		logic        dir;
		logic        first;
		logic        last;
		logic [3:0]  pos;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUBK,
		ST_B0,
		ST_BLK,
		ST_FIN
	} back_state_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] r;
		unique case (rnd)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// byte k of a block sits at bits 127-8k down
	function automatic logic [7:0] blk_byte(input logic [127:0] b, input int k);
		return b[127-8*k -: 8];
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [3:0] rnd);
		logic [31:0] tmp;
		logic [31:0] w0, w1, w2, w3;
		tmp = {SBOX[blk_byte(rk, 13)] ^ rcon(rnd), SBOX[blk_byte(rk, 14)],
			SBOX[blk_byte(rk, 15)], SBOX[blk_byte(rk, 12)]};
		w0 = rk[127:96] ^ tmp;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
		input logic last);
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] x;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			t[i] = SBOX[blk_byte(s, (i & 3) + 4 * (((i >> 2) + (i & 3)) & 3))];
		end
		for (int c = 0; c < 4; c++) begin
			x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			m[4*c]   = t[4*c]   ^ x ^ xtime(t[4*c]   ^ t[4*c+1]);
			m[4*c+1] = t[4*c+1] ^ x ^ xtime(t[4*c+1] ^ t[4*c+2]);
			m[4*c+2] = t[4*c+2] ^ x ^ xtime(t[4*c+2] ^ t[4*c+3]);
			m[4*c+3] = t[4*c+3] ^ x ^ xtime(t[4*c+3] ^ t[4*c]);
		end
		for (int i = 0; i < 16; i++) begin
			r[127-8*i -: 8] = (last ? t[i] : m[i]) ^ blk_byte(rk, i);
		end
		return r;
	endfunction

	// doubling in GF(2^128) for the CMAC subkeys
	function automatic logic [127:0] dbl(input logic [127:0] x);
		return {x[126:0], 1'b0} ^ {120'b0, (x[127] ? RED_POLY : 8'h00)};
	endfunction

endpackage

// ===== hdl/lmic_aes.sv =====
// Iterative AES-128 encryptor, one round per cycle, keys expanded on the fly
module lmic_aes (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] blk_in,
	input  logic [127:0] key,
	output logic         busy,
	output logic [127:0] res
);
	import lmic_pkg::*;

	logic [127:0] st_q;
	logic [127:0] rk_q;
	logic [3:0]   rnd_q;
	logic         busy_q;
	logic [127:0] rk_nx;

	assign rk_nx = key_next(rk_q, rnd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 4'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= 4'd1;
		end else if (busy_q) begin
			busy_q <= (rnd_q != LAST_RND);
			rnd_q  <= rnd_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= blk_in ^ key;
			rk_q <= key;
		end else if (busy_q) begin
			st_q <= aes_round(st_q, rk_nx, rnd_q == LAST_RND);
			rk_q <= rk_nx;
		end
	end

	assign busy = busy_q;
	assign res  = st_q;
endmodule

// ===== hdl/lmic_fifo.sv =====
// Short queue of classified words between front and back
module lmic_fifo #(
	parameter int DEPTH = lmic_pkg::FIFO_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lmic_pkg::entry_t wr_data,
	input  logic            pop,
	output lmic_pkg::entry_t rd_data,
	output logic            full,
	output logic            empty
);
	import lmic_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end
endmodule

// ===== hdl/lmic_front.sv =====
// Input side: takes message bytes, tracks framing, tags first and last words
module lmic_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic [7:0]      msg_len,
	input  logic [15:0]     frame_counter,
	input  logic            direction,
	input  logic            q_full,
	output logic            q_push,
	output lmic_pkg::entry_t q_data
);
	import lmic_pkg::*;

	logic       in_msg_q;
	logic [7:0] cnt_q;
	logic [7:0] len_q;
	logic       take;
	logic       first;
	logic       drop;
	logic [7:0] len_cur;
	logic       last;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign first    = !in_msg_q;
	assign len_cur  = first ? msg_len : len_q;
	// zero-length message: swallow the word
	assign drop     = first && (msg_len == 8'd0);
	assign last     = ((cnt_q + 8'd1) == len_cur);
	assign q_push   = take && !drop;

	always_comb begin
		q_data.data  = data_byte;
		q_data.len   = msg_len;
		q_data.ctr   = frame_counter;
		q_data.dir   = direction;
		q_data.first = first;
		q_data.last  = last;
		q_data.pos   = cnt_q[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			cnt_q    <= 8'd0;
			len_q    <= 8'd0;
		end else if (q_push) begin
			if (last) begin
				in_msg_q <= 1'b0;
				cnt_q    <= 8'd0;
			end else begin
				in_msg_q <= 1'b1;
				cnt_q    <= cnt_q + 8'd1;
			end
			if (first) begin
				len_q <= msg_len;
			end
		end
	end
endmodule

// ===== hdl/lmic_back.sv =====
// CMAC engine: subkeys, B0, CBC chaining, final block and result register
module lmic_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lmic_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lmic_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              q_empty,
	input  lmic_pkg::entry_t                  q_data,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       mic
);
	import lmic_pkg::*;

	back_state_t  state_q, state_d;
	logic         inmsg_q;
	logic [127:0] chain_q, chain_d;
	logic         chain_we;
	logic [127:0] k1_q, k2_q;
	logic         sub_we;
	logic [31:0]  dev_q;
	logic [63:0]  khi_q, klo_q;
	logic         outv_q;
	logic [31:0]  mic_q;
	logic         out_load;
	logic         inmsg_set, inmsg_clr;

	logic         aes_start;
	logic [127:0] aes_in;
	logic         aes_busy;
	logic [127:0] aes_res;

	logic [127:0] chain_x;
	logic [127:0] pad;
	logic [127:0] fin_blk;
	logic [127:0] b0_blk;
	logic [127:0] k1_nx;

	lmic_aes u_aes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (aes_start),
		.blk_in (aes_in),
		.key    ({khi_q, klo_q}),
		.busy   (aes_busy),
		.res    (aes_res)
	);

	assign chain_x = chain_q ^ ({q_data.data, 120'b0} >> {q_data.pos, 3'b0});
	assign pad     = {PAD_BYTE, 120'b0} >> {q_data.pos + 4'd1, 3'b0};
	assign fin_blk = (q_data.pos == LAST_POS) ? (chain_x ^ k1_q) : (chain_x ^ pad ^ k2_q);
	assign b0_blk  = {B0_TAG, 32'b0, 7'b0, q_data.dir,
		dev_q[7:0], dev_q[15:8], dev_q[23:16], dev_q[31:24],
		q_data.ctr[7:0], q_data.ctr[15:8], 24'b0, q_data.len};
	assign k1_nx   = dbl(aes_res);

	always_comb begin
		state_d   = state_q;
		aes_start = 1'b0;
		aes_in    = '0;
		q_pop     = 1'b0;
		chain_we  = 1'b0;
		chain_d   = chain_x;
		sub_we    = 1'b0;
		inmsg_set = 1'b0;
		inmsg_clr = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_data.first && !inmsg_q) begin
						aes_start = 1'b1;
						state_d   = ST_SUBK;
					end else begin
						q_pop = 1'b1;
						if (q_data.last) begin
							aes_start = 1'b1;
							aes_in    = fin_blk;
							inmsg_clr = 1'b1;
							state_d   = ST_FIN;
						end else if (q_data.pos == LAST_POS) begin
							aes_start = 1'b1;
							aes_in    = chain_x;
							state_d   = ST_BLK;
						end else begin
							chain_we = 1'b1;
						end
					end
				end
			end
			ST_SUBK: begin
				if (!aes_busy) begin
					sub_we    = 1'b1;
					aes_start = 1'b1;
					aes_in    = b0_blk;
					state_d   = ST_B0;
				end
			end
			ST_B0: begin
				if (!aes_busy) begin
					chain_we  = 1'b1;
					chain_d   = aes_res;
					inmsg_set = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_BLK: begin
				if (!aes_busy) begin
					chain_we = 1'b1;
					chain_d  = aes_res;
					state_d  = ST_IDLE;
				end
			end
			ST_FIN: begin
				// hold the tag until the output slot frees up
				if (!aes_busy && (!outv_q || out_ready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inmsg_q <= 1'b0;
			outv_q  <= 1'b0;
			dev_q   <= '0;
			khi_q   <= '0;
			klo_q   <= '0;
		end else begin
			state_q <= state_d;
			if (inmsg_set) begin
				inmsg_q <= 1'b1;
			end else if (inmsg_clr) begin
				inmsg_q <= 1'b0;
			end
			if (out_load) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
			if (cfg_we) begin
				priority case (cfg_idx)
					REG_DEV_ADDR:   dev_q <= cfg_data[31:0];
					REG_NWK_KEY_HI: khi_q <= cfg_data;
					REG_NWK_KEY_LO: klo_q <= cfg_data;
					default:        ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_q <= chain_d;
		end
		if (sub_we) begin
			k1_q <= k1_nx;
			k2_q <= dbl(k1_nx);
		end
		if (out_load) begin
			mic_q <= {aes_res[103:96], aes_res[111:104], aes_res[119:112], aes_res[127:120]};
		end
	end

	assign out_valid = outv_q;
	assign mic       = mic_q;
endmodule

// ===== hdl/lorawan_mic_cmac.sv =====
// LoRaWAN MIC (AES-128-CMAC) top level
//
// Configuration: write dev_addr (index 0), nwk_key_hi (1) and nwk_key_lo (2)
// through cfg_we/cfg_idx/cfg_data while no message is in flight.
// Input: one message byte per word on in_valid/in_ready with msg_len,
// frame_counter and direction; those three are taken on a message's first
// byte only. A first byte with msg_len zero is dropped and gives no result.
// Output: one 32-bit mic word on out_valid/out_ready after each message's
// last byte, byte 0 of the tag in bits 7:0.
// Timing: a queue of FIFO_DEPTH words sits between the input side and the
// CMAC engine, so bytes are taken at one per cycle until it fills. The
// engine runs one AES unit at one round per cycle: a message's first byte
// waits for the subkey and B0 blocks, each further byte is folded into the
// chain register, and every full 16-byte block is run through the AES unit.
// The tag is registered once the final block leaves the AES unit and the output is free.
// Stall: with out_ready low the offered tag holds and the next tag waits;
// the queue keeps taking bytes until full. Reset clears all control state
// and the key and address registers; the block is ready the cycle after.
module lorawan_mic_cmac #(
	parameter int FIFO_DEPTH = lmic_pkg::FIFO_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lmic_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lmic_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic [7:0]                      msg_len,
	input  logic [15:0]                     frame_counter,
	input  logic                            direction,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     mic
);
	import lmic_pkg::*;

	entry_t push_data;
	entry_t head;
	logic   push, pop, full, empty;

	lmic_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.msg_len       (msg_len),
		.frame_counter (frame_counter),
		.direction     (direction),
		.q_full        (full),
		.q_push        (push),
		.q_data        (push_data)
	);

	lmic_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (head),
		.full    (full),
		.empty   (empty)
	);

	lmic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.q_empty   (empty),
		.q_data    (head),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mic       (mic)
	);
endmodule

// ===== hdl/lmic_chk.sv =====
// Port-level checks for the LoRaWAN MIC block, bound to the top level
`include "lorawan_mic_cmac_defines.svh"

module lmic_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] mic
);
	// a stalled tag holds
	`LMIC_ASSERT(a_mic_hold, out_valid && !out_ready, ##1 (out_valid && $stable(mic)))
	// an offered byte stays offered until taken
	`LMIC_ASSERT(a_in_hold, in_valid && !in_ready, ##1 in_valid)
	// leaving reset: queue accepting, no result
	`LMIC_ASSERT_RST(a_rst_clean, !$past(arst_n), !out_valid && in_ready)
endmodule

bind lorawan_mic_cmac lmic_chk u_lmic_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.mic       (mic)
);

// ===== test/lorawan_mic_cmac_test.sv =====
// Testbench for lorawan_mic_cmac: byte stream in, MIC words checked against an AES-CMAC predictor
`timescale 1ns / 1ps

module lorawan_mic_cmac_test;
	import lmic_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [7:0]  data;
		logic [7:0]  len;
		logic [15:0] ctr;
		logic        dir;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic [7:0] msg_len;
	logic [15:0] frame_counter;
	logic direction;
	logic out_valid;
	logic out_ready;
	logic [31:0] mic;

	// predictor copy of the registers and the CMAC state
	logic [31:0] addr_reg;
	logic [127:0] key_reg;
	logic [127:0] chain, k1, k2;
	logic [7:0] taken, want_len;
	logic busy;
	logic [31:0] mic_q[$];

	int errors = 0;
	int cycles = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	int hold_left = 0;

	const logic [7:0] sb[256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// zero-length drops, short messages at the field extremes, one exact block,
	// and fields that change after the first byte
	const stim_t directed[25] = '{
		'{8'h5a, 8'd0, 16'h1234, 1'b1},
		'{8'h00, 8'd1, 16'h0000, 1'b0},
		'{8'hff, 8'd1, 16'hffff, 1'b1},
		'{8'h00, 8'd16, 16'h00ff, 1'b0}, '{8'h11, 8'd0, 16'h0, 1'b1},
		'{8'h22, 8'd1, 16'h0, 1'b0}, '{8'h33, 8'd255, 16'hffff, 1'b1},
		'{8'h44, 8'd0, 16'h0, 1'b0}, '{8'h55, 8'd0, 16'h0, 1'b0},
		'{8'h66, 8'd0, 16'h0, 1'b0}, '{8'h77, 8'd0, 16'h0, 1'b0},
		'{8'h88, 8'd0, 16'h0, 1'b0}, '{8'h99, 8'd0, 16'h0, 1'b0},
		'{8'haa, 8'd0, 16'h0, 1'b0}, '{8'hbb, 8'd0, 16'h0, 1'b0},
		'{8'hcc, 8'd0, 16'h0, 1'b0}, '{8'hdd, 8'd0, 16'h0, 1'b0},
		'{8'hee, 8'd0, 16'h0, 1'b0}, '{8'hff, 8'd0, 16'h0, 1'b0},
		'{8'h01, 8'd3, 16'hff00, 1'b1},
		'{8'h80, 8'd0, 16'h0000, 1'b0},
		'{8'h7f, 8'd200, 16'h5555, 1'b0},
		'{8'h00, 8'd0, 16'h0000, 1'b0},
		'{8'hc3, 8'd2, 16'h00ff, 1'b0},
		'{8'h3c, 8'd0, 16'h0000, 1'b1}
	};

	lorawan_mic_cmac uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .msg_len(msg_len),
		.frame_counter(frame_counter), .direction(direction),
		.out_valid(out_valid), .out_ready(out_ready), .mic(mic)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] gf2(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] blk);
		logic [7:0] s[16], t[16], rk[16], w[4];
		logic [7:0] rc, a0, a1, a2, a3, x;
		logic [127:0] res;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[127-8*i -: 8];
			s[i] = blk[127-8*i -: 8] ^ rk[i];
		end
		for (int r = 1; r <= 10; r++) begin
			w[0] = sb[rk[13]] ^ rc;
			w[1] = sb[rk[14]];
			w[2] = sb[rk[15]];
			w[3] = sb[rk[12]];
			for (int i = 0; i < 16; i++) begin
				rk[i] = rk[i] ^ ((i < 4) ? w[i] : rk[i-4]);
			end
			rc = gf2(rc);
			for (int i = 0; i < 16; i++) begin
				t[i] = sb[s[(i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)]];
			end
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ x ^ gf2(a0 ^ a1);
					t[4*c+1] = a1 ^ x ^ gf2(a1 ^ a2);
					t[4*c+2] = a2 ^ x ^ gf2(a2 ^ a3);
					t[4*c+3] = a3 ^ x ^ gf2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) begin
				s[i] = t[i] ^ rk[i];
			end
		end
		for (int i = 0; i < 16; i++) begin
			res[127-8*i -: 8] = s[i];
		end
		return res;
	endfunction

	function automatic logic [127:0] gf_double(input logic [127:0] v);
		return {v[126:0], 1'b0} ^ {120'b0, (v[127] ? 8'h87 : 8'h00)};
	endfunction

	// advance the CMAC state by one accepted byte; push the MIC on the last one
	task automatic mic_absorb(input logic [7:0] d, input logic [7:0] l, input logic [15:0] c,
		input logic dr);
		logic [3:0] pos;
		if (!busy) begin
			if (l == 8'd0)
				return;
			want_len = l;
			taken = 8'd0;
			busy = 1'b1;
			k1 = gf_double(aes128(key_reg, 128'd0));
			k2 = gf_double(k1);
			chain = aes128(key_reg, {8'h49, 32'd0, 7'd0, dr, addr_reg[7:0], addr_reg[15:8],
				addr_reg[23:16], addr_reg[31:24], c[7:0], c[15:8], 24'd0, l});
		end
		pos = taken[3:0];
		chain[127-8*pos -: 8] = chain[127-8*pos -: 8] ^ d;
		taken = taken + 8'd1;
		if (taken == want_len) begin
			if (pos == 4'd15) begin
				chain = chain ^ k1;
			end else begin
				chain[127-8*(pos+1) -: 8] = chain[127-8*(pos+1) -: 8] ^ 8'h80;
				chain = chain ^ k2;
			end
			chain = aes128(key_reg, chain);
			mic_q.push_back({chain[103:96], chain[111:104], chain[119:112], chain[127:120]});
			busy = 1'b0;
			taken = 8'd0;
		end else if (pos == 4'd15) begin
			chain = aes128(key_reg, chain);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("lorawan_mic_cmac test failed");
			$finish;
		end
	end

	// monitor both handshakes on the edge, pre-update values
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (in_valid && in_ready)
				mic_absorb(data_byte, msg_len, frame_counter, direction);
			if (out_valid && out_ready) begin
				if (mic_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected mic word %h", mic);
				end else begin
					want = mic_q.pop_front();
					if (mic !== want) begin
						errors++;
						if (errors <= 10)
							$display("mic mismatch: expected %h, got %h", want, mic);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_pct);
		end
	end

	task automatic put_byte(input logic [7:0] d, input logic [7:0] l, input logic [15:0] c,
		input logic dr);
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		msg_len <= l;
		frame_counter <= c;
		direction <= dr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (mic_q.size() != 0) @(posedge clk);
		// settle before the next phase; dropped zero-length words never reach the engine
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEV_ADDR)
			addr_reg = val[31:0];
		else if (idx == REG_NWK_KEY_HI)
			key_reg[127:64] = val;
		else
			key_reg[63:0] = val;
	endtask

	task automatic send_message(input int n);
		logic [7:0] l;
		logic [15:0] c;
		logic dr;
		l = n[7:0];
		c = 16'($urandom);
		dr = 1'($urandom_range(1));
		put_byte(8'($urandom), l, c, dr);
		for (int i = 1; i < n; i++)
			put_byte(8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom_range(1)));
	endtask

	initial begin
		int sent;
		int n;
		bit held;
		logic [63:0] a, h, l;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_DEV_ADDR;
		cfg_data <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		msg_len <= '0;
		frame_counter <= '0;
		direction <= 1'b0;
		out_ready <= 1'b0;
		addr_reg = '0;
		key_reg = '0;
		chain = '0;
		k1 = '0;
		k2 = '0;
		taken = '0;
		want_len = '0;
		busy = 1'b0;
		held = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows first, with the registers still at their reset values
		foreach (directed[i])
			put_byte(directed[i].data, directed[i].len, directed[i].ctr, directed[i].dir);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: begin a = 64'd0; h = 64'd0; l = 64'd0; end
				1: begin a = 64'hffffffff; h = '1; l = '1; end
				default: begin
					a = 64'($urandom);
					h = {$urandom, $urandom};
					l = {$urandom, $urandom};
				end
			endcase
			write_reg(REG_DEV_ADDR, a);
			write_reg(REG_NWK_KEY_HI, h);
			write_reg(REG_NWK_KEY_LO, l);
			snd_pct = (ph == 1) ? 61 : (ph == 3) ? 6 : 0;
			rcv_pct = (ph == 2) ? 61 : (ph == 3) ? 6 : 0;
			sent = 0;
			while (sent < 420) begin
				if (ph == 0 && sent >= 100 && !held) begin
					held = 1'b1;
					hold_left = 400;
				end
				if (ph == 1 && sent > 200 && sent < 230) begin
					// pause until every word is back
					in_valid <= 1'b0;
					@(posedge clk);
					while (mic_q.size() != 0) @(posedge clk);
					sent = 230;
				end
				if ($urandom_range(99) < 12) begin
					put_byte(8'($urandom), 8'd0, 16'($urandom), 1'($urandom_range(1)));
				end else begin
					case ($urandom_range(19))
						0: n = 255;
						1: n = 16 * $urandom_range(1, 3);
						2: n = 1;
						default: n = $urandom_range(1, 40);
					endcase
					send_message(n);
					sent += n;
				end
			end
		end

		wait_drained();
		if (errors == 0) begin
			$display("lorawan_mic_cmac test passed");
		end else begin
			$display("lorawan_mic_cmac test failed");
		end
		$finish;
	end

endmodule
